### hw/rtl/max_rectangle_binary_matrix_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the maximal rectangle unit
// Concurrent checks, compiled to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MAX_RECTANGLE_BINARY_MATRIX_UNIT_MACROS_SVH
`define MAX_RECTANGLE_BINARY_MATRIX_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MRBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrbm: assertion failed");
`define MRBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrbm: assertion failed");
`else
`define MRBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MRBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/mrbm_pkg.sv
// ----------------------------------------------------------------------------
// mrbm_pkg
// Widths, constants and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package mrbm_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 256;

  localparam int COLS_W   = 7;
  localparam int HEIGHT_W = 9;
  localparam int AREA_W   = 15;
  localparam int ROWS_W   = 9;

  localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;
  localparam int AREA_MAX = 32767;

  typedef struct packed {
    logic cell_take;
    logic cell_rd;
    logic cell_wr;
    logic lpass_init;
    logic hist_rd;
    logic h_lat;
    logic stk_rd_top;
    logic pop;
    logic push_left;
    logic rpass_init;
    logic push_right;
    logic mul;
    logic acc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic last_col;
    logic pop_cond;
    logic idx_last;
    logic idx_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/mrbm_in_if.sv
// ----------------------------------------------------------------------------
// mrbm_in_if
// Cell input channel: one matrix cell per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrbm_in_if ();
  logic valid;
  logic ready;
  logic cell_bit;
  logic first_of_matrix;

  modport source (output valid, output cell_bit, output first_of_matrix, input ready);
  modport sink (input valid, input cell_bit, input first_of_matrix, output ready);
endinterface

`default_nettype wire

### hw/rtl/mrbm_out_if.sv
// ----------------------------------------------------------------------------
// mrbm_out_if
// Result channel: running maximum area and completed row count.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrbm_out_if import mrbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AREA_W-1:0]   max_area;
  logic [ROWS_W-1:0]   rows_done;

  modport source (output valid, output max_area, output rows_done, input ready);
  modport sink (input valid, input max_area, input rows_done, output ready);
endinterface

`default_nettype wire

### hw/rtl/mrbm_cfg_if.sv
// ----------------------------------------------------------------------------
// mrbm_cfg_if
// Configuration write channel for the column count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrbm_cfg_if import mrbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COLS_W-1:0] cols_in_use;

  modport source (output valid, output cols_in_use, input ready);
  modport sink (input valid, input cols_in_use, output ready);
endinterface

`default_nettype wire

### hw/rtl/mrbm_ctrl.sv
// ----------------------------------------------------------------------------
// mrbm_ctrl
// Sequencer for cell updates and the two stack sweeps at each row end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbm_ctrl import mrbm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  sts_t      sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_C_RD  = 4'd1;
  localparam logic [3:0] S_C_WR  = 4'd2;
  localparam logic [3:0] S_L_RD  = 4'd3;
  localparam logic [3:0] S_L_H   = 4'd4;
  localparam logic [3:0] S_L_CMP = 4'd5;
  localparam logic [3:0] S_R_RD  = 4'd6;
  localparam logic [3:0] S_R_H   = 4'd7;
  localparam logic [3:0] S_R_CMP = 4'd8;
  localparam logic [3:0] S_R_MUL = 4'd9;
  localparam logic [3:0] S_R_ACC = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cell_take = 1'b1;
          state_nxt     = S_C_RD;
        end
      end
      S_C_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = S_C_WR;
      end
      S_C_WR: begin
        cmd.cell_wr = 1'b1;
        if (sts.last_col) begin
          cmd.lpass_init = 1'b1;
          state_nxt      = S_L_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_L_RD: begin
        cmd.hist_rd = 1'b1;
        state_nxt   = S_L_H;
      end
      S_L_H: begin
        cmd.h_lat      = 1'b1;
        cmd.stk_rd_top = 1'b1;
        state_nxt      = S_L_CMP;
      end
      S_L_CMP: begin
        if (sts.pop_cond) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.push_left = 1'b1;
          if (sts.idx_last) begin
            cmd.rpass_init = 1'b1;
            state_nxt      = S_R_RD;
          end else begin
            state_nxt = S_L_RD;
          end
        end
      end
      S_R_RD: begin
        cmd.hist_rd = 1'b1;
        state_nxt   = S_R_H;
      end
      S_R_H: begin
        cmd.h_lat      = 1'b1;
        cmd.stk_rd_top = 1'b1;
        state_nxt      = S_R_CMP;
      end
      S_R_CMP: begin
        if (sts.pop_cond) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.push_right = 1'b1;
          state_nxt      = S_R_MUL;
        end
      end
      S_R_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_R_ACC;
      end
      S_R_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.idx_zero ? S_FIN : S_R_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mrbm_dp.sv
// ----------------------------------------------------------------------------
// mrbm_dp
// Height histogram, monotonic stack, bound store and area accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbm_dp import mrbm_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  wire logic              cell_bit,
  input  wire logic              first_of_matrix,
  input  wire logic              cfg_we,
  input  wire logic [COLS_W-1:0] cfg_cols,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [AREA_W-1:0]      out_area,
  output logic [ROWS_W-1:0]      out_rows
);

  localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NW    = $clog2(MAX_COLS + 1);
  localparam int PW    = NW + HEIGHT_W;
  localparam int CAP_I = (MAX_ROWS < 511) ? MAX_ROWS : 511;
  localparam logic [HEIGHT_W-1:0] H_CAP = HEIGHT_W'(CAP_I);
  localparam logic [ROWS_W-1:0]   R_CAP = ROWS_W'(CAP_I);

  logic [HEIGHT_W-1:0] ht_mem [MAX_COLS];
  logic [HEIGHT_W-1:0] sh_mem [MAX_COLS];
  logic [AW-1:0]       sc_mem [MAX_COLS];
  logic [NW-1:0]       lb_mem [MAX_COLS];

  logic [COLS_W-1:0]   cols_r, cols_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic                first_row_r, first_row_nxt;
  logic [AREA_W-1:0]   best_r, best_nxt;
  logic [ROWS_W-1:0]   rows_r, rows_nxt;
  logic [NW-1:0]       top_r, top_nxt;
  logic [AW-1:0]       i_r, i_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                bit_r;
  logic [AW-1:0]       col_r;
  logic [HEIGHT_W-1:0] h_r;
  logic [NW-1:0]       lb_r;
  logic [NW-1:0]       width_r;
  logic [PW-1:0]       prod_r;
  logic [PW-1:0]       row_best_r;
  logic [HEIGHT_W-1:0] ht_rd_r;
  logic [HEIGHT_W-1:0] sh_rd_r;
  logic [AW-1:0]       sc_rd_r;
  logic [NW-1:0]       lb_rd_r;
  logic [AREA_W-1:0]   out_area_r;
  logic [ROWS_W-1:0]   out_rows_r;

  logic [NW-1:0]       n;
  logic [NW-1:0]       n_m1;
  logic [AW-1:0]       pos_eff;
  logic [AW-1:0]       col_take;
  logic [HEIGHT_W-1:0] ht_new;
  logic [AW-1:0]       ht_raddr;
  logic [NW-1:0]       top_m1;
  logic [NW-1:0]       top_m2;
  logic [AW-1:0]       stk_raddr;
  logic [NW-1:0]       lbp;
  logic [NW-1:0]       right;
  logic [AREA_W-1:0]   row_area;

  always_comb begin
    if (cols_r == '0) begin
      n = NW'(1);
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      n = NW'(MAX_COLS);
    end else begin
      n = NW'(cols_r);
    end
  end

  assign n_m1     = n - 1'b1;
  assign pos_eff  = first_of_matrix ? '0 : pos_r;
  assign col_take = (NW'(pos_eff) >= n) ? n_m1[AW-1:0] : pos_eff;

  always_comb begin
    if (first_row_r) begin
      ht_new = HEIGHT_W'(bit_r);
    end else if (!bit_r) begin
      ht_new = '0;
    end else if (ht_rd_r < H_CAP) begin
      ht_new = ht_rd_r + 1'b1;
    end else begin
      ht_new = H_CAP;
    end
  end

  assign ht_raddr  = cmd.cell_rd ? col_r : i_r;
  assign top_m1    = top_r - 1'b1;
  assign top_m2    = top_r - 2'd2;
  assign stk_raddr = cmd.pop ? top_m2[AW-1:0] : top_m1[AW-1:0];
  assign lbp       = (top_r != '0) ? (NW'(sc_rd_r) + 1'b1) : '0;
  assign right     = (top_r != '0) ? NW'(sc_rd_r) : n;
  assign row_area  = (32'(row_best_r) > 32'(AREA_MAX)) ? AREA_W'(AREA_MAX)
                                                       : AREA_W'(row_best_r);

  assign sts.last_col = (NW'(col_r) == n_m1);
  assign sts.pop_cond = (top_r != '0) && (sh_rd_r >= h_r);
  assign sts.idx_last = (NW'(i_r) == n_m1);
  assign sts.idx_zero = (i_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    cols_nxt      = cfg_we ? cfg_cols : cols_r;
    pos_nxt       = pos_r;
    first_row_nxt = first_row_r;
    best_nxt      = best_r;
    rows_nxt      = rows_r;
    top_nxt       = top_r;
    i_nxt         = i_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    if (cmd.cell_take && first_of_matrix) begin
      best_nxt      = '0;
      rows_nxt      = '0;
      first_row_nxt = 1'b1;
    end
    if (cmd.cell_wr) begin
      pos_nxt = sts.last_col ? '0 : (col_r + 1'b1);
    end

    if (cmd.lpass_init || cmd.rpass_init) begin
      top_nxt = '0;
    end else if (cmd.pop) begin
      top_nxt = top_m1;
    end else if (cmd.push_left || cmd.push_right) begin
      top_nxt = top_r + 1'b1;
    end

    if (cmd.lpass_init) begin
      i_nxt = '0;
    end else if (cmd.rpass_init) begin
      i_nxt = n_m1[AW-1:0];
    end else if (cmd.push_left) begin
      i_nxt = i_r + 1'b1;
    end else if (cmd.acc) begin
      i_nxt = i_r - 1'b1;
    end

    if (cmd.fin) begin
      best_nxt      = (row_area > best_r) ? row_area : best_r;
      rows_nxt      = (rows_r < R_CAP) ? (rows_r + 1'b1) : rows_r;
      pos_nxt       = '0;
      first_row_nxt = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= COLS_RESET;
      pos_r       <= '0;
      first_row_r <= 1'b1;
      best_r      <= '0;
      rows_r      <= '0;
      top_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cols_r      <= cols_nxt;
      pos_r       <= pos_nxt;
      first_row_r <= first_row_nxt;
      best_r      <= best_nxt;
      rows_r      <= rows_nxt;
      top_r       <= top_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_take) begin
      bit_r <= cell_bit;
      col_r <= col_take;
    end
    if (cmd.h_lat) begin
      h_r  <= ht_rd_r;
      lb_r <= lb_rd_r;
    end
    if (cmd.push_right) begin
      width_r <= right - lb_r;
    end
    if (cmd.mul) begin
      prod_r <= PW'(width_r) * PW'(h_r);
    end
    if (cmd.lpass_init) begin
      row_best_r <= '0;
    end else if (cmd.acc && (prod_r > row_best_r)) begin
      row_best_r <= prod_r;
    end
    if (cmd.fin) begin
      out_area_r <= best_nxt;
      out_rows_r <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_rd || cmd.hist_rd) begin
      ht_rd_r <= ht_mem[ht_raddr];
    end
    if (cmd.cell_wr) begin
      ht_mem[col_r] <= ht_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop || cmd.stk_rd_top) begin
      sh_rd_r <= sh_mem[stk_raddr];
      sc_rd_r <= sc_mem[stk_raddr];
    end
    if (cmd.push_left || cmd.push_right) begin
      sh_mem[top_r[AW-1:0]] <= h_r;
      sc_mem[top_r[AW-1:0]] <= i_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_rd) begin
      lb_rd_r <= lb_mem[i_r];
    end
    if (cmd.push_left) begin
      lb_mem[i_r] <= lbp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_area  = out_area_r;
  assign out_rows  = out_rows_r;

endmodule

`default_nettype wire

### hw/rtl/max_rectangle_binary_matrix_unit.sv
// ----------------------------------------------------------------------------
// max_rectangle_binary_matrix_unit
// Streams a binary matrix and reports, after each row, the largest all-ones rectangle so far.
// ----------------------------------------------------------------------------
// Cells arrive in row-major order, cols_in_use per row. A cell that ends no
// row passes through accept, height read and height write. The last cell of
// a row also starts two stack sweeps over the n columns through single-port
// height, stack and bound memories: the left sweep reads, latches and
// compares each column, the right sweep also multiplies and accumulates, and
// each sweep adds a pop step per stack pop (at most n - 1 per sweep); a final
// step loads the result register. Each row yields one result; it waits in an
// output register and a new cell is accepted while it does, but the next row
// end holds in its final state until that register is free. No clearing pass
// runs after reset.
`default_nettype none

`include "max_rectangle_binary_matrix_unit_macros.svh"

module max_rectangle_binary_matrix_unit import mrbm_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input wire logic    clk,
  input wire logic    rst_n,
  mrbm_in_if.sink     in_ch,
  mrbm_out_if.source  out_ch,
  mrbm_cfg_if.sink    cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  mrbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrbm_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cell_bit        (in_ch.cell_bit),
    .first_of_matrix (in_ch.first_of_matrix),
    .cfg_we          (cfg_ch.valid),
    .cfg_cols        (cfg_ch.cols_in_use),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_area        (out_ch.max_area),
    .out_rows        (out_ch.rows_done)
  );

  `MRBM_ASSERT_NEXT(a_take_leaves_idle, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `MRBM_ASSERT_SAME(a_result_has_row, clk, rst_n, out_ch.valid, out_ch.rows_done != '0)
  `MRBM_ASSERT_SAME(a_result_from_pass, clk, rst_n, $rose(out_ch.valid), $past(!in_ch.ready))

endmodule

`default_nettype wire
